@@ rtl/pce_pkg.sv @@
// ----------------------------------------------------------------------------
// pce_pkg
// Types and codes shared by the priority collection engine.
// ----------------------------------------------------------------------------
package pce_pkg;

  // Request codes
  localparam logic [2:0] REQ_ADD     = 3'd0;
  localparam logic [2:0] REQ_PROMOTE = 3'd1;
  localparam logic [2:0] REQ_PEEK    = 3'd2;
  localparam logic [2:0] REQ_POP     = 3'd3;
  localparam logic [2:0] REQ_LOOKUP  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // What the shared compare unit looks for during a scan
  typedef enum logic [1:0] {
    SCAN_FREE,
    SCAN_ID,
    SCAN_MAX
  } scan_mode_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] payload_in;
    logic [31:0] entry_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic [31:0] payload_out;
    logic [15:0] priority_out;
    logic        is_live;
  } rsp_t;

endpackage

@@ rtl/pce_match.sv @@
// ----------------------------------------------------------------------------
// pce_match
// Shared compare unit: decides whether the slot under scan replaces the
// best candidate held so far.
// ----------------------------------------------------------------------------
module pce_match
  import pce_pkg::*;
#(
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned IDENT_BITS    = 32
) (
  input  scan_mode_e               mode_i,
  input  logic [31:0]              key_id_i,
  input  logic                     cand_valid_i,
  input  logic [IDENT_BITS-1:0]    cand_ident_i,
  input  logic [PRIORITY_BITS-1:0] cand_prio_i,
  input  logic                     best_found_i,
  input  logic [IDENT_BITS-1:0]    best_ident_i,
  input  logic [PRIORITY_BITS-1:0] best_prio_i,
  output logic                     take_o
);

  logic id_hit;
  logic beats;

  // a key wider than the identifier space never matches
  assign id_hit = (key_id_i == 32'(cand_ident_i));
  // ties go to the newer identifier
  assign beats  = (cand_prio_i > best_prio_i) ||
                  ((cand_prio_i == best_prio_i) && (cand_ident_i > best_ident_i));

  always_comb begin
    unique case (mode_i)
      SCAN_FREE: take_o = !cand_valid_i && !best_found_i;
      SCAN_ID:   take_o = cand_valid_i && !best_found_i && id_hit;
      SCAN_MAX:  take_o = cand_valid_i && (!best_found_i || beats);
      default:   take_o = 1'b0;
    endcase
  end

endmodule

@@ rtl/priority_collection_engine_unit.sv @@
// ----------------------------------------------------------------------------
// priority_collection_engine_unit
// Bounded priority table with add, promote, peek, pop and lookup.
// ----------------------------------------------------------------------------
// Each request is a transfer on start_i while busy_o is low. For every request
// the slot memory is swept one slot per cycle through its single read port;
// each slot is compared once its registered read data returns, and a closing
// state writes back and registers the answer.
// The answer appears for exactly one cycle with done_o high; the receiver
// cannot stall it, so it must take the transfer in that cycle. After reset
// the unit clears the valid flag of every slot, one per cycle, and holds
// busy_o high until every slot is cleared, before the first request.
// ----------------------------------------------------------------------------
module priority_collection_engine_unit
  import pce_pkg::*;
#(
  parameter int unsigned ENTRIES       = 64,
  parameter int unsigned PAYLOAD_BITS  = 32,
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned IDENT_BITS    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  // slot word: valid | ident | priority | payload
  localparam int unsigned WW    = 1 + IDENT_BITS + PRIORITY_BITS + PAYLOAD_BITS;
  localparam int unsigned V_BIT = WW - 1;
  localparam int unsigned I_TOP = WW - 2;
  localparam int unsigned P_TOP = PRIORITY_BITS + PAYLOAD_BITS - 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q;

  // slot memory, one read and one write port
  logic [WW-1:0] mem [ENTRIES];
  logic [WW-1:0] rdata_q;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;

  // sequencer state
  logic [CW-1:0] cnt_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  req_t          req_q;
  logic [CW-1:0] live_count_q;
  logic [IDENT_BITS-1:0] next_ident_q;

  // best candidate of the current sweep
  logic                     found_q;
  logic [AW-1:0]            best_idx_q;
  logic [IDENT_BITS-1:0]    best_ident_q;
  logic [PRIORITY_BITS-1:0] best_prio_q;
  logic [PAYLOAD_BITS-1:0]  best_payload_q;

  scan_mode_e               mode;
  logic                     take;
  logic                     cand_valid;
  logic [IDENT_BITS-1:0]    cand_ident;
  logic [PRIORITY_BITS-1:0] cand_prio;
  logic [PAYLOAD_BITS-1:0]  cand_payload;
  logic [PRIORITY_BITS-1:0] prio_inc;
  logic                     table_full;
  logic                     ids_out;
  logic                     add_ok;
  rsp_t                     rsp_d;

  assign cand_valid   = rdata_q[V_BIT];
  assign cand_ident   = rdata_q[I_TOP -: IDENT_BITS];
  assign cand_prio    = rdata_q[P_TOP -: PRIORITY_BITS];
  assign cand_payload = rdata_q[PAYLOAD_BITS-1:0];

  always_comb begin
    unique case (req_q.req_type)
      REQ_ADD:                mode = SCAN_FREE;
      REQ_PROMOTE, REQ_LOOKUP: mode = SCAN_ID;
      default:                mode = SCAN_MAX;
    endcase
  end

  pce_match #(
    .PRIORITY_BITS (PRIORITY_BITS),
    .IDENT_BITS    (IDENT_BITS)
  ) u_match (
    .mode_i       (mode),
    .key_id_i     (req_q.entry_id),
    .cand_valid_i (cand_valid),
    .cand_ident_i (cand_ident),
    .cand_prio_i  (cand_prio),
    .best_found_i (found_q),
    .best_ident_i (best_ident_q),
    .best_prio_i  (best_prio_q),
    .take_o       (take)
  );

  // promote saturates at the top priority
  assign prio_inc   = (best_prio_q == {PRIORITY_BITS{1'b1}}) ? best_prio_q
                                                             : best_prio_q + 1'b1;
  assign table_full = (live_count_q == CW'(ENTRIES));
  assign ids_out    = (next_ident_q == {IDENT_BITS{1'b1}});
  assign add_ok     = !table_full && !ids_out && found_q;

  // closing-cycle answer and write-back, and the slot clear after reset
  always_comb begin
    rsp_d     = '0;
    mem_we    = 1'b0;
    mem_waddr = best_idx_q;
    mem_wdata = {1'b1, best_ident_q, best_prio_q, best_payload_q};
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_q[AW-1:0];
      mem_wdata = '0;
    end else if (state_q == S_DONE) begin
      unique case (req_q.req_type)
        REQ_ADD: begin
          if (table_full || (!ids_out && !found_q)) begin
            rsp_d.status = ST_FULL;
          end else if (ids_out) begin
            rsp_d.status = ST_EXHAUSTED;
          end else begin
            rsp_d.result_id = 32'(next_ident_q);
            mem_we    = 1'b1;
            mem_wdata = {1'b1, next_ident_q, {PRIORITY_BITS{1'b0}},
                         PAYLOAD_BITS'(req_q.payload_in)};
          end
        end
        REQ_PROMOTE: begin
          if (!found_q) begin
            rsp_d.status = ST_UNKNOWN;
          end else begin
            rsp_d.result_id    = 32'(best_ident_q);
            rsp_d.payload_out  = 32'(best_payload_q);
            rsp_d.priority_out = 16'(prio_inc);
            rsp_d.is_live      = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = {1'b1, best_ident_q, prio_inc, best_payload_q};
          end
        end
        REQ_PEEK, REQ_POP, REQ_LOOKUP: begin
          if (!found_q) begin
            rsp_d.status = (req_q.req_type == REQ_LOOKUP) ? ST_UNKNOWN : ST_EMPTY;
          end else begin
            rsp_d.result_id    = 32'(best_ident_q);
            rsp_d.payload_out  = 32'(best_payload_q);
            rsp_d.priority_out = 16'(best_prio_q);
            rsp_d.is_live      = 1'b1;
            if (req_q.req_type == REQ_POP) begin
              mem_we    = 1'b1;
              mem_wdata = {1'b0, best_ident_q, best_prio_q, best_payload_q};
            end
          end
        end
        default: ;  // unused codes answer ok with all fields zero
      endcase
    end
  end

  assign mem_re    = (state_q == S_SCAN) && (cnt_q < CW'(ENTRIES));
  assign mem_raddr = cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      cnt_q          <= '0;
      rd_vld_q       <= 1'b0;
      rd_idx_q       <= '0;
      req_q          <= '0;
      live_count_q   <= '0;
      next_ident_q   <= '0;
      found_q        <= 1'b0;
      best_idx_q     <= '0;
      best_ident_q   <= '0;
      best_prio_q    <= '0;
      best_payload_q <= '0;
      done_o         <= 1'b0;
      rsp_o          <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (cnt_q == CW'(ENTRIES - 1)) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            req_q    <= req_i;
            cnt_q    <= '0;
            rd_vld_q <= 1'b0;
            found_q  <= 1'b0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read issued at cnt_q, compared in the following cycle
          rd_vld_q <= mem_re;
          rd_idx_q <= cnt_q[AW-1:0];
          if (rd_vld_q && take) begin
            found_q        <= 1'b1;
            best_idx_q     <= rd_idx_q;
            best_ident_q   <= cand_ident;
            best_prio_q    <= cand_prio;
            best_payload_q <= cand_payload;
          end
          if (cnt_q == CW'(ENTRIES)) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DONE: begin
          rsp_o   <= rsp_d;
          done_o  <= 1'b1;
          state_q <= S_IDLE;
          if ((req_q.req_type == REQ_ADD) && add_ok) begin
            next_ident_q <= next_ident_q + 1'b1;
            live_count_q <= live_count_q + 1'b1;
          end
          if ((req_q.req_type == REQ_POP) && found_q && (live_count_q != '0)) begin
            live_count_q <= live_count_q - 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
